### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tst_pkg.sv
// Package of the timeout slot table: constants, codes and controller/datapath structs.
`default_nettype none

package tst_pkg;

  localparam int unsigned NumSlotsDefault = 64;
  localparam int unsigned MaxResults      = 64;
  localparam int unsigned KeyW            = 64;
  localparam int unsigned TimeW           = 64;
  localparam int unsigned CntW            = $clog2(MaxResults + 1);

  // request codes (input tuser)
  localparam logic [1:0] ReqAdd    = 2'd0;
  localparam logic [1:0] ReqCancel = 2'd1;
  localparam logic [1:0] ReqTick   = 2'd2;
  localparam logic [1:0] ReqNone   = 2'd3;

  // event codes (output tuser)
  localparam logic [1:0] KindExpired   = 2'd0;
  localparam logic [1:0] KindNoSpace   = 2'd1;
  localparam logic [1:0] KindCancelled = 2'd2;
  localparam logic [1:0] KindNotFound  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic       start;      // latch request, restart scan
    logic       step;       // advance scan pipeline
    logic       take;       // apply hit to slot under compare
    logic       pend_load;  // park expired key of slot under compare
    logic       pend_clr;   // drop parked key
    logic       emit;       // load output register
    logic       emit_pend;  // output key from parked key, else request key
    logic [1:0] emit_kind;
    logic       emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       b_vld;     // compare stage holds a slot
    logic       hit;       // slot under compare matches the request
    logic       b_last;    // slot under compare is the last slot
    logic       out_free;  // output register can take a word
    logic       pend_vld;
    logic       cnt_last;  // next expiry is the final one allowed per tick
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/tst_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module tst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tst_ctrl.sv
// Controller state machine of the timeout slot table.
`default_nettype none

module tst_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  input  wire logic [1:0]    s_req_i,
  output logic               s_ready_o,
  input  wire tst_pkg::sts_t sts_i,
  output tst_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    s_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        s_ready_o = 1'b1;
        // unused request code is swallowed without a scan
        if (s_valid_i && s_req_i != tst_pkg::ReqNone) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        if (!sts_i.b_vld) begin
          cmd_o.step = 1'b1;
        end else begin
          case (sts_i.op)
            tst_pkg::ReqAdd: begin
              if (sts_i.hit) begin
                cmd_o.take = 1'b1;
                state_d    = StIdle;
              end else if (sts_i.b_last) begin
                if (sts_i.out_free) begin
                  cmd_o.emit      = 1'b1;
                  cmd_o.emit_kind = tst_pkg::KindNoSpace;
                  cmd_o.emit_last = 1'b1;
                  state_d         = StIdle;
                end
              end else begin
                cmd_o.step = 1'b1;
              end
            end
            tst_pkg::ReqCancel: begin
              if (sts_i.hit) begin
                if (sts_i.out_free) begin
                  cmd_o.take      = 1'b1;
                  cmd_o.emit      = 1'b1;
                  cmd_o.emit_kind = tst_pkg::KindCancelled;
                  cmd_o.emit_last = 1'b1;
                  state_d         = StIdle;
                end
              end else if (sts_i.b_last) begin
                if (sts_i.out_free) begin
                  cmd_o.emit      = 1'b1;
                  cmd_o.emit_kind = tst_pkg::KindNotFound;
                  cmd_o.emit_last = 1'b1;
                  state_d         = StIdle;
                end
              end else begin
                cmd_o.step = 1'b1;
              end
            end
            tst_pkg::ReqTick: begin
              if (sts_i.hit) begin
                // previous expiry leaves as a non-final word, this one gets parked
                if (!sts_i.pend_vld || sts_i.out_free) begin
                  cmd_o.take      = 1'b1;
                  cmd_o.pend_load = 1'b1;
                  cmd_o.emit      = sts_i.pend_vld;
                  cmd_o.emit_pend = 1'b1;
                  cmd_o.emit_kind = tst_pkg::KindExpired;
                  if (sts_i.cnt_last || sts_i.b_last) begin
                    state_d = StFlush;
                  end else begin
                    cmd_o.step = 1'b1;
                  end
                end
              end else if (sts_i.b_last) begin
                state_d = StFlush;
              end else begin
                cmd_o.step = 1'b1;
              end
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StFlush: begin
        if (!sts_i.pend_vld) begin
          state_d = StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_pend = 1'b1;
          cmd_o.emit_kind = tst_pkg::KindExpired;
          cmd_o.emit_last = 1'b1;
          cmd_o.pend_clr  = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tst_dpath.sv
// Datapath of the timeout slot table: slot RAM, valid bits, scan pipeline, output register.
`default_nettype none

module tst_dpath #(
  parameter int unsigned NumSlots = tst_pkg::NumSlotsDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [1:0]                req_i,
  input  wire logic [tst_pkg::KeyW-1:0]  key_i,
  input  wire logic [tst_pkg::TimeW-1:0] delay_i,
  input  wire logic [tst_pkg::TimeW-1:0] now_i,
  input  wire tst_pkg::cmd_t             cmd_i,
  output tst_pkg::sts_t                  sts_o,
  output logic                           out_vld_o,
  input  wire logic                      out_rdy_i,
  output logic [1:0]                     out_kind_o,
  output logic [tst_pkg::KeyW-1:0]       out_key_o,
  output logic                           out_last_o
);

  localparam int unsigned AW      = $clog2(NumSlots);
  localparam int unsigned EntryW  = tst_pkg::KeyW + tst_pkg::TimeW;
  localparam logic [AW-1:0] LastIdx = AW'(NumSlots - 1);

  // latched request
  logic [1:0]                op_q;
  logic [tst_pkg::KeyW-1:0]  key_q;
  logic [tst_pkg::TimeW-1:0] now_q, dl_q;

  // scan pipeline: issue address, then compare stage
  logic [AW-1:0] a_q, b_idx_q;
  logic          a_done_q, b_vld_q;

  logic [NumSlots-1:0] valid_q;

  logic                      pend_vld_q;
  logic [tst_pkg::KeyW-1:0]  pend_key_q;
  logic [tst_pkg::CntW-1:0]  cnt_q;

  logic                      out_vld_q, out_last_q;
  logic [1:0]                out_kind_q;
  logic [tst_pkg::KeyW-1:0]  out_key_q;

  logic [EntryW-1:0]         rd_data;
  logic [tst_pkg::KeyW-1:0]  rd_key;
  logic [tst_pkg::TimeW-1:0] rd_dl;
  logic                      b_valid, hit, out_free, rd_en, wr_en;

  assign rd_key = rd_data[tst_pkg::KeyW-1:0];
  assign rd_dl  = rd_data[EntryW-1:tst_pkg::KeyW];

  assign rd_en = cmd_i.step && !a_done_q;
  assign wr_en = cmd_i.take && (op_q == tst_pkg::ReqAdd);

  tst_ram #(
    .Width(EntryW),
    .Depth(NumSlots)
  ) u_slot_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(b_idx_q),
    .wr_data_i({dl_q, key_q}),
    .rd_en_i  (rd_en),
    .rd_addr_i(a_q),
    .rd_data_o(rd_data)
  );

  assign b_valid = valid_q[b_idx_q];

  always_comb begin
    case (op_q)
      tst_pkg::ReqAdd:    hit = !b_valid;
      tst_pkg::ReqCancel: hit = b_valid && (rd_key == key_q);
      tst_pkg::ReqTick:   hit = b_valid && (now_q >= rd_dl);
      default:            hit = 1'b0;
    endcase
  end

  assign out_free = !out_vld_q || out_rdy_i;

  assign sts_o.op       = op_q;
  assign sts_o.b_vld    = b_vld_q;
  assign sts_o.hit      = hit;
  assign sts_o.b_last   = (b_idx_q == LastIdx);
  assign sts_o.out_free = out_free;
  assign sts_o.pend_vld = pend_vld_q;
  assign sts_o.cnt_last = (cnt_q == tst_pkg::CntW'(tst_pkg::MaxResults - 1));

  // request latch, parked key and output register load; deadline wraps modulo 2^64
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= key_i;
      now_q <= now_i;
      dl_q  <= now_i + delay_i;
    end
    if (cmd_i.pend_load) begin
      pend_key_q <= rd_key;
    end
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.emit_kind;
      out_key_q  <= cmd_i.emit_pend ? pend_key_q : key_q;
      out_last_q <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= tst_pkg::ReqNone;
      a_q        <= '0;
      a_done_q   <= 1'b0;
      b_idx_q    <= '0;
      b_vld_q    <= 1'b0;
      valid_q    <= '0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        op_q       <= req_i;
        a_q        <= '0;
        a_done_q   <= 1'b0;
        b_vld_q    <= 1'b0;
        pend_vld_q <= 1'b0;
        cnt_q      <= '0;
      end else begin
        if (cmd_i.step) begin
          b_idx_q <= a_q;
          b_vld_q <= !a_done_q;
          if (!a_done_q) begin
            if (a_q == LastIdx) begin
              a_done_q <= 1'b1;
            end else begin
              a_q <= a_q + 1'b1;
            end
          end
        end
        if (cmd_i.pend_load) begin
          pend_vld_q <= 1'b1;
          cnt_q      <= cnt_q + 1'b1;
        end else if (cmd_i.pend_clr) begin
          pend_vld_q <= 1'b0;
        end
      end
      if (cmd_i.take) begin
        valid_q[b_idx_q] <= (op_q == tst_pkg::ReqAdd);
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_kind_o = out_kind_q;
  assign out_key_o  = out_key_q;
  assign out_last_o = out_last_q;

endmodule

`default_nettype wire

### hw/rtl/timeout_slot_table_unit.sv
// Top level of the timeout slot table: controller, datapath and port assertions.
// Holds NumSlots pending timeouts (key plus 64-bit deadline) in a slot RAM with one
// valid flip-flop per slot; reset clears the valid bits at once, so there is no
// clearing pass. A request word carries a code in tuser: add stores the key with
// deadline now+delay (modulo 2^64) in the lowest free slot and answers only when
// the table is full (no space); cancel frees the lowest active slot with that key
// and answers cancelled or not found; tick emits, in slot order, one expired word
// per active slot whose deadline is at or before now (unsigned), at most 64 per
// tick, and frees them; tlast marks the final word of a request. Code 3 is dropped.
// One request is handled at a time. The slots are scanned one per cycle through the
// single read port of the slot RAM, unless output back-pressure stalls the scan. The
// scan ends at the first free slot for add, the first match for cancel, the last slot
// for a miss and for tick, or the 64th expired slot; a tick then passes through a
// flush state. The next request is taken in the cycle after the scan ends (for tick,
// after the flush state), while the last word may still wait in the output register.
`default_nettype none

`include "assert_macros.svh"

module timeout_slot_table_unit #(
  parameter int unsigned NumSlots = tst_pkg::NumSlotsDefault  // 2 .. 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // request words
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [191:0] s_axis_tdata_i,  // user_key[63:0], delay_ns[127:64], now_ns[191:128]
  input  wire logic [1:0]   s_axis_tuser_i,  // req_type[1:0]
  // event words
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [63:0]       m_axis_tdata_o,  // event_key[63:0]
  output logic [1:0]        m_axis_tuser_o,  // event_kind[1:0]
  output logic              m_axis_tlast_o   // last
);

  tst_pkg::cmd_t cmd;
  tst_pkg::sts_t sts;

  tst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_req_i  (s_axis_tuser_i),
    .s_ready_o(s_axis_tready_o),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  tst_dpath #(
    .NumSlots(NumSlots)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (s_axis_tuser_i),
    .key_i     (s_axis_tdata_i[63:0]),
    .delay_i   (s_axis_tdata_i[127:64]),
    .now_i     (s_axis_tdata_i[191:128]),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_vld_o (m_axis_tvalid_o),
    .out_rdy_i (m_axis_tready_i),
    .out_kind_o(m_axis_tuser_o),
    .out_key_o (m_axis_tdata_o),
    .out_last_o(m_axis_tlast_o)
  );

  // a word is never loaded over one that has not left
  `ASSERT_IMPL(a_emit_free, cmd.emit, sts.out_free, "emit into occupied output register")
  // a slot is only changed when the compare stage holds a matching slot
  `ASSERT_IMPL(a_take_hit, cmd.take, sts.b_vld && sts.hit, "slot update without a hit")
  // a real request closes the input until its scan is over
  `ASSERT_NEXT(a_busy, s_axis_tvalid_i && s_axis_tready_o &&
               s_axis_tuser_i != tst_pkg::ReqNone, !s_axis_tready_o,
               "request accepted during a scan")

endmodule

`default_nettype wire

### tb/timeout_slot_table_unit_tb.sv
// Self-checking testbench of the timeout slot table: stream driver, event checker, predictor.
`timescale 1ns / 100ps

module timeout_slot_table_unit_tb;
  import tst_pkg::*;

  localparam int SlotCount   = NumSlotsDefault;
  localparam int RandomItems = 130;
  localparam int IdleLimit   = 3000;  // cycles with no word moving on either side
  localparam int DrainCycles = 200;   // > one full scan plus flush, after the last event
  localparam int PoolSize    = 12;

  typedef struct {
    logic [1:0]  req;
    logic [63:0] key;
    logic [63:0] delay;
    logic [63:0] now;
    bit          hold;   // wait until every event owed so far has arrived
  } req_item_t;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] key;
    logic        last;
  } event_t;

  typedef enum logic [1:0] {RxOpen, RxLight, RxHeavy, RxPeriodic} rx_mode_e;

  logic         clk_i     = 1'b0;
  logic         rst_ni    = 1'b0;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata   = '0;
  logic [1:0]   s_tuser   = ReqNone;
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  // timer table as the testbench sees it
  bit          slot_busy [SlotCount];
  logic [63:0] slot_tag  [SlotCount];
  logic [63:0] slot_due  [SlotCount];

  req_item_t request_q[$];
  event_t    owed_events[$];

  bit       events_drained = 1'b1;
  int       mismatches     = 0;
  int       idle_cycles    = 0;
  int       burst_left     = 0;
  int       gap_left       = 0;
  rx_mode_e rx_mode        = RxOpen;
  int       rx_mode_left   = 0;

  always #5 clk_i = ~clk_i;

  timeout_slot_table_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  // Advance the table by one accepted request and queue the events it owes.
  function automatic void apply_request(req_item_t r);
    bit done;
    int n;
    done = 1'b0;
    n    = 0;
    case (r.req)
      ReqAdd: begin
        for (int i = 0; i < SlotCount && !done; i++) begin
          if (!slot_busy[i]) begin
            slot_busy[i] = 1'b1;
            slot_tag[i]  = r.key;
            slot_due[i]  = r.now + r.delay;  // wraps mod 2^64
            done         = 1'b1;
          end
        end
        if (!done) owed_events.push_back(event_t'{KindNoSpace, r.key, 1'b1});
      end
      ReqCancel: begin
        for (int i = 0; i < SlotCount && !done; i++) begin
          if (slot_busy[i] && slot_tag[i] == r.key) begin
            slot_busy[i] = 1'b0;
            done         = 1'b1;
          end
        end
        owed_events.push_back(event_t'{done ? KindCancelled : KindNotFound, r.key, 1'b1});
      end
      ReqTick: begin
        for (int i = 0; i < SlotCount && n < MaxResults; i++) begin
          if (slot_busy[i] && r.now >= slot_due[i]) begin
            slot_busy[i] = 1'b0;
            owed_events.push_back(event_t'{KindExpired, slot_tag[i], 1'b0});
            n++;
          end
        end
        if (n > 0) owed_events[owed_events.size() - 1].last = 1'b1;
      end
      default: ;  // unused code: dropped
    endcase
  endfunction

  function automatic void queue_req(logic [1:0] req, logic [63:0] key, logic [63:0] delay,
                                    logic [63:0] now, bit hold);
    request_q.push_back(req_item_t'{req, key, delay, now, hold});
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sender: bursts of random length, random gaps, hold items wait until all owed events have arrived.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    req_item_t nxt;
    if (!rst_ni) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      s_tuser    <= ReqNone;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_q.size() == 0 ||
                   (request_q[0].hold && (s_tvalid || !events_drained))) begin
        // stay idle after the last word so the drained flag covers it
        s_tvalid <= 1'b0;
      end else begin
        nxt      = request_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {nxt.now, nxt.delay, nxt.key};
        s_tuser  <= nxt.req;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: the stall pattern switches at random among open, light, heavy and periodic modes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready     <= 1'b0;
      rx_mode      <= RxOpen;
      rx_mode_left <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(20, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RxOpen:  m_tready <= 1'b1;
        RxLight: m_tready <= ($urandom_range(0, 3) != 0);
        RxHeavy: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_mode_left % 8 != 0);
      endcase
    end
  end

  // Checker: results at this edge stem from earlier requests, so check before predicting.
  always @(posedge clk_i or negedge rst_ni) begin : check_events
    event_t want;
    if (!rst_ni) begin
      events_drained <= 1'b1;
      idle_cycles    <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected event word: kind %0d key %h last %0b",
                     $time, m_tuser, m_tdata, m_tlast);
        end else begin
          want = owed_events.pop_front();
          if (m_tuser !== want.kind || m_tdata !== want.key || m_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: event mismatch: want kind %0d key %h last %0b, ",
                        "got kind %0d key %h last %0b"},
                       $time, want.kind, want.key, want.last, m_tuser, m_tdata, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready)
        apply_request(req_item_t'{s_tuser, s_tdata[63:0], s_tdata[127:64],
                                  s_tdata[191:128], 1'b0});
      events_drained <= (owed_events.size() == 0);
      idle_cycles    <= ((m_tvalid && m_tready) || (s_tvalid && s_tready)) ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: no word moved for too long.
  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("timeout_slot_table_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    int          counted;
    int          pick;
    int          n;
    logic [63:0] t_now;
    logic [63:0] dly;
    logic [63:0] key_pool [PoolSize];

    // --- directed ---
    queue_req(ReqAdd, 64'd0, 64'd0, 64'd0, 1'b0);          // slot 0, due at 0
    queue_req(ReqAdd, '1, '1, '1, 1'b0);                   // slot 1, due wraps to ..FE
    queue_req(ReqTick, 64'd0, 64'd0, 64'd0, 1'b0);         // due exactly now: slot 0
    queue_req(ReqTick, '1, '1, 64'hFFFF_FFFF_FFFF_FFFD, 1'b0);  // nothing due
    queue_req(ReqTick, 64'd0, 64'd0, '1, 1'b1);            // slot 1 expires
    queue_req(ReqCancel, 64'h5, 64'd0, 64'd0, 1'b0);       // not found
    // duplicate keys: lowest match goes first
    queue_req(ReqAdd, 64'hA5A5, 64'd100, 64'd1000, 1'b0);
    queue_req(ReqAdd, 64'hA5A5, 64'd50, 64'd1000, 1'b0);
    queue_req(ReqAdd, 64'hB6B6, 64'd10, 64'd1000, 1'b0);
    queue_req(ReqCancel, 64'hA5A5, 64'd0, 64'd1000, 1'b0);
    queue_req(ReqCancel, 64'hA5A5, 64'd0, 64'd1000, 1'b0);
    queue_req(ReqCancel, 64'hA5A5, 64'd0, 64'd1000, 1'b0);
    queue_req(ReqNone, 64'hB6B6, '1, '1, 1'b0);            // dropped, must not cancel
    queue_req(ReqCancel, 64'hB6B6, 64'd0, 64'd1000, 1'b0);
    // deadline wraps past zero and is due at once
    queue_req(ReqAdd, 64'hC7C7, 64'h20, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
    queue_req(ReqTick, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1);
    // due on the exact deadline, not one before
    queue_req(ReqAdd, 64'hD8D8, 64'd0, 64'd500, 1'b0);
    queue_req(ReqTick, 64'd0, 64'd0, 64'd499, 1'b0);
    queue_req(ReqTick, 64'd0, 64'd0, 64'd500, 1'b0);
    // full table: no space, refill a hole, then a tick that owes all slots
    for (int i = 0; i < SlotCount; i++)
      queue_req(ReqAdd, 64'h1000 + i, i * 3, 64'd2000, 1'b0);
    queue_req(ReqAdd, '1, 64'd1, 64'd2000, 1'b0);
    queue_req(ReqCancel, 64'h100A, 64'd0, 64'd2000, 1'b0);
    queue_req(ReqAdd, 64'hE9E9, 64'd7, 64'd2000, 1'b0);
    queue_req(ReqAdd, 64'hF0F0, 64'd7, 64'd2000, 1'b0);
    queue_req(ReqTick, 64'd0, 64'd0, '1, 1'b1);

    // --- random: mostly add/cancel/tick on a small key pool with advancing time ---
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = rand64();
    t_now   = 64'd5000;
    counted = 0;
    while (counted < RandomItems) begin
      t_now = t_now + $urandom_range(0, 400);
      if ($urandom_range(0, 49) == 0) t_now = rand64();
      pick = $urandom_range(0, 99);
      if (pick < 43) begin
        n = (pick < 3) ? $urandom_range(20, 70) : $urandom_range(1, 6);  // rare fill bursts
        repeat (n) begin
          case ($urandom_range(0, 19))
            0, 1:    dly = rand64();
            2:       dly = '1;
            3:       dly = '0;
            default: dly = $urandom_range(0, 600);
          endcase
          queue_req(ReqAdd, ($urandom_range(0, 9) == 0) ? rand64() :
                    key_pool[$urandom_range(0, PoolSize - 1)], dly, t_now,
                    $urandom_range(0, 32) == 0);
        end
        counted += n;
      end else if (pick < 63) begin
        queue_req(ReqCancel, ($urandom_range(0, 4) == 0) ? rand64() :
                  key_pool[$urandom_range(0, PoolSize - 1)], rand64(), t_now,
                  $urandom_range(0, 32) == 0);
        counted++;
      end else if (pick < 88) begin
        queue_req(ReqTick, rand64(), rand64(),
                  ($urandom_range(0, 9) == 0) ? rand64() : t_now, $urandom_range(0, 32) == 0);
        counted++;
      end else if (pick < 95) begin
        queue_req(ReqTick, rand64(), rand64(), '1, $urandom_range(0, 1));  // flush all
        counted++;
      end else begin
        queue_req(ReqNone, rand64(), rand64(), rand64(), 1'b0);  // noise, not counted
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (owed_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("timeout_slot_table_unit_tb: clean");
    end else begin
      $display("timeout_slot_table_unit_tb: errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tst_pkg.sv
hw/rtl/tst_ram.sv
hw/rtl/tst_ctrl.sv
hw/rtl/tst_dpath.sv
hw/rtl/timeout_slot_table_unit.sv
tb/timeout_slot_table_unit_tb.sv
